[design/sma_pkg.sv]
// sma_pkg: shared types and constants for the sign-magnitude ALU
// no dependencies; used by every module of the block by scoped names
`default_nettype none

package sma_pkg;

  // port width of the magnitude fields
  localparam int unsigned MAG_PORT_W = 32;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2
  } op_t;

  // control that travels with each beat down the chain
  typedef struct packed {
    logic valid;
    logic sign;
  } ctl_t;

endpackage

`default_nettype wire

[design/sma_front.sv]
// sma_front: operand capture, add/subtract by sign, multiply set-up
// depends on sma_pkg (op_t, ctl_t, MAG_PORT_W)
`default_nettype none

module sma_front #(
  parameter int unsigned MAG_W = 32
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   en,
  input  wire logic                                   take,
  input  wire logic [1:0]                             opcode,
  input  wire logic                                   a_sign,
  input  wire logic [sma_pkg::MAG_PORT_W-1:0]         a_mag,
  input  wire logic                                   b_sign,
  input  wire logic [sma_pkg::MAG_PORT_W-1:0]         b_mag,
  output sma_pkg::ctl_t                               ctl,
  output logic [2*MAG_W-1:0]                          acc,
  output logic [2*MAG_W-1:0]                          mcand,
  output logic [MAG_W-1:0]                            mplier
);

  localparam int unsigned ACC_W = 2 * MAG_W;

  logic [MAG_W-1:0]   ma;
  logic [MAG_W-1:0]   mb;
  logic               sb_eff;
  logic [MAG_W:0]     sum_ab;
  logic [MAG_W-1:0]   diff_ab;
  logic               a_ge_b;
  sma_pkg::ctl_t      ctl_next;
  logic [ACC_W-1:0]   acc_next;
  logic [ACC_W-1:0]   mcand_next;
  logic [MAG_W-1:0]   mplier_next;

  assign ma     = a_mag[MAG_W-1:0];
  assign mb     = b_mag[MAG_W-1:0];
  assign sb_eff = (sma_pkg::op_t'(opcode) == sma_pkg::OP_SUB) ? ~b_sign : b_sign;
  assign a_ge_b = (ma >= mb);
  assign sum_ab = {1'b0, ma} + {1'b0, mb};
  assign diff_ab = a_ge_b ? (ma - mb) : (mb - ma);

  always_comb begin
    ctl_next.valid = take;
    ctl_next.sign  = 1'b0;
    acc_next       = '0;
    mcand_next     = '0;
    mplier_next    = '0;
    case (sma_pkg::op_t'(opcode))
      sma_pkg::OP_ADD, sma_pkg::OP_SUB: begin
        if (a_sign == sb_eff) begin
          acc_next      = ACC_W'(sum_ab);
          ctl_next.sign = a_sign;
        end else begin
          acc_next      = ACC_W'(diff_ab);
          ctl_next.sign = a_ge_b ? a_sign : sb_eff;
        end
      end
      sma_pkg::OP_MUL: begin
        mcand_next    = ACC_W'(ma);
        mplier_next   = mb;
        ctl_next.sign = a_sign ^ b_sign;
      end
      default: begin
        // unused opcode gives a positive zero
        ctl_next.sign = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
    end else if (en) begin
      ctl.valid <= ctl_next.valid;
    end
    if (en) begin
      ctl.sign <= ctl_next.sign;
      acc      <= acc_next;
      mcand    <= mcand_next;
      mplier   <= mplier_next;
    end
  end

endmodule

`default_nettype wire

[design/sma_cell.sv]
// sma_cell: one step of the shift-and-add chain, handles one multiplier bit
// depends on sma_pkg (ctl_t)
`default_nettype none

module sma_cell #(
  parameter int unsigned MAG_W = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  en,
  input  wire sma_pkg::ctl_t         ctl_in,
  input  wire logic [2*MAG_W-1:0]    acc_in,
  input  wire logic [2*MAG_W-1:0]    mcand_in,
  input  wire logic [MAG_W-1:0]      mplier_in,
  output sma_pkg::ctl_t              ctl,
  output logic [2*MAG_W-1:0]         acc,
  output logic [2*MAG_W-1:0]         mcand,
  output logic [MAG_W-1:0]           mplier
);

  localparam int unsigned ACC_W = 2 * MAG_W;

  logic [ACC_W-1:0] acc_next;

  // add/subtract beats carry a zero multiplier, so they pass unchanged
  assign acc_next = acc_in + (mplier_in[0] ? mcand_in : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
    end else if (en) begin
      ctl.valid <= ctl_in.valid;
    end
    if (en) begin
      ctl.sign <= ctl_in.sign;
      acc      <= acc_next;
      mcand    <= {mcand_in[ACC_W-2:0], 1'b0};
      mplier   <= {1'b0, mplier_in[MAG_W-1:1]};
    end
  end

endmodule

`default_nettype wire

[design/sma_back.sv]
// sma_back: truncation, overflow detect, zero sign fix and output register
// depends on sma_pkg (ctl_t, MAG_PORT_W)
`default_nettype none

module sma_back #(
  parameter int unsigned MAG_W = 32
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               en,
  input  wire sma_pkg::ctl_t                      ctl_in,
  input  wire logic [2*MAG_W-1:0]                 acc_in,
  output logic                                    out_valid,
  output logic                                    res_sign,
  output logic [sma_pkg::MAG_PORT_W-1:0]          res_mag,
  output logic                                    overflow
);

  localparam int unsigned PORT_W = sma_pkg::MAG_PORT_W;

  logic [MAG_W-1:0] mag;
  logic             ovf;

  assign mag = acc_in[MAG_W-1:0];
  assign ovf = |acc_in[2*MAG_W-1:MAG_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= ctl_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // zero is always positive
      res_sign <= ctl_in.sign & (|mag);
      res_mag  <= PORT_W'(mag);
      overflow <= ovf;
    end
  end

endmodule

`default_nettype wire

[design/sign_magnitude_alu.sv]
// sign_magnitude_alu: sign-magnitude add, subtract and multiply
// each beat is registered in sma_front, in every cell and in sma_back
// throughput: one beat per cycle; the multiplier is a row of cells, one per
// multiplier bit, and every beat walks the whole row
// the row stalls as a whole while a result beat waits at the output
// reset clears the valid bits only; depends on sma_pkg and the sma_* modules
`default_nettype none

module sign_magnitude_alu #(
  parameter int unsigned MAG_WIDTH = 32
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [1:0]                         opcode,
  input  wire logic                               a_sign,
  input  wire logic [sma_pkg::MAG_PORT_W-1:0]     a_mag,
  input  wire logic                               b_sign,
  input  wire logic [sma_pkg::MAG_PORT_W-1:0]     b_mag,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic                                    res_sign,
  output logic [sma_pkg::MAG_PORT_W-1:0]          res_mag,
  output logic                                    overflow
);

  localparam int unsigned MAG_W =
    (MAG_WIDTH < sma_pkg::MAG_PORT_W) ? MAG_WIDTH : sma_pkg::MAG_PORT_W;
  localparam int unsigned ACC_W = 2 * MAG_W;

  logic advance;

  sma_pkg::ctl_t    ctl_c    [MAG_W+1];
  logic [ACC_W-1:0] acc_c    [MAG_W+1];
  logic [ACC_W-1:0] mcand_c  [MAG_W+1];
  logic [MAG_W-1:0] mplier_c [MAG_W+1];

  // whole row moves unless a result beat is held at the output
  assign advance  = ~out_valid | out_ready;
  assign in_ready = advance;

  sma_front #(
    .MAG_W (MAG_W)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .en     (advance),
    .take   (in_valid),
    .opcode (opcode),
    .a_sign (a_sign),
    .a_mag  (a_mag),
    .b_sign (b_sign),
    .b_mag  (b_mag),
    .ctl    (ctl_c[0]),
    .acc    (acc_c[0]),
    .mcand  (mcand_c[0]),
    .mplier (mplier_c[0])
  );

  for (genvar i = 0; i < MAG_W; i++) begin : g_cell
    sma_cell #(
      .MAG_W (MAG_W)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (advance),
      .ctl_in    (ctl_c[i]),
      .acc_in    (acc_c[i]),
      .mcand_in  (mcand_c[i]),
      .mplier_in (mplier_c[i]),
      .ctl       (ctl_c[i+1]),
      .acc       (acc_c[i+1]),
      .mcand     (mcand_c[i+1]),
      .mplier    (mplier_c[i+1])
    );
  end

  sma_back #(
    .MAG_W (MAG_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .en        (advance),
    .ctl_in    (ctl_c[MAG_W]),
    .acc_in    (acc_c[MAG_W]),
    .out_valid (out_valid),
    .res_sign  (res_sign),
    .res_mag   (res_mag),
    .overflow  (overflow)
  );

endmodule

`default_nettype wire
